@@ rtl/core/mlbd_pkg.sv @@
// Shared types, constants and the load arithmetic of the load-balance decider.
package mlbd_pkg;

    localparam int CORE_COUNT = 4;
    localparam int IDX_W      = 2;
    localparam int COUNT_W    = 8;
    localparam int LOAD_W     = 7;
    localparam int MODE_W     = 2;
    localparam int MASK_W     = 4;
    localparam int ACT_W      = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 4;
    localparam int SDATA_W    = 16;
    localparam int MDATA_W    = 16;

    localparam logic [LOAD_W-1:0] LOAD_MAX   = 7'd100;
    localparam logic [LOAD_W-1:0] PUSH_LEVEL = 7'd60;
    localparam logic [LOAD_W-1:0] PULL_LEVEL = 7'd20;
    localparam logic [LOAD_W-1:0] LOAD_GAP   = 7'd20;
    localparam logic [11:0]       LOAD_PER_TASK = 12'd10;

    localparam logic [CFG_ADDR_W-1:0] REG_BALANCE_MODE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IPI_ENABLE   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ONLINE_MASK  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PULL   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_HYBRID = 2'd3;

    localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PULL = 2'd2;

    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_BALANCE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_RESULT
    } state_t;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic               smp_we;
        logic               upd_en;
        logic [IDX_W-1:0]   core;
        logic [COUNT_W-1:0] count;
        logic               busy;
    } cell_cmd_t;

    // Search word walking down the row of cells
    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  req;
        logic              min_found;
        logic [LOAD_W-1:0] lo_load;
        logic [IDX_W-1:0]  min_idx;
        logic              max_found;
        logic [LOAD_W-1:0] hi_load;
        logic [IDX_W-1:0]  max_idx;
        logic [LOAD_W-1:0] self_load;
        logic [LOAD_W-1:0] load0;
    } token_t;

    // Instantaneous load: (count + busy) * 10, capped at 100
    function automatic logic [LOAD_W-1:0] load_now(input logic [COUNT_W-1:0] count,
                                                   input logic busy);
        logic [11:0] sum;
        logic [11:0] prod;
        sum  = {4'b0, count} + {11'b0, busy};
        prod = sum * LOAD_PER_TASK;
        return (prod > {5'b0, LOAD_MAX}) ? LOAD_MAX : prod[LOAD_W-1:0];
    endfunction

    // Smoothed load: floor((3 * old + now) / 4)
    function automatic logic [LOAD_W-1:0] load_avg(input logic [LOAD_W-1:0] old_load,
                                                   input logic [LOAD_W-1:0] now_load);
        logic [8:0] acc;
        acc = {2'b0, old_load} * 9'd3 + {2'b0, now_load};
        return acc[8:2];
    endfunction

endpackage

@@ rtl/core/multicore_load_balance_decider.sv @@
// Top level of the load-balance decider: config registers, cell row, decision and output word.
//
//  channel   | direction | handshake              | carries
//  s_        | in        | s_tvalid / s_tready    | sample or balance request word
//  m_        | out       | m_tvalid / m_tready    | balance decision word
//  cfg_      | in        | cfg_wr_en (no wait)    | balance_mode, ipi_enable, online_mask
//
// A sample word is stored at its accepting edge and leaves the input open. A balance word
// updates the smoothed loads of the online cells at its accepting edge when interrupts are
// enabled and the mode is not none, then starts a search word that walks the row through the
// register of each cell; the decision is registered, then moved into the output register, and
// the input reopens with that move, so no new word is taken while a balance search runs.
// Reset clears all stored counts, busy flags and loads; registers return to
// mode hybrid, interrupts enabled, core 0 online.
// A stalled output holds its word while the input stays open; a balance word that
// finishes its search meanwhile holds its decision, input closed, until the output frees.
module multicore_load_balance_decider (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [1:0] core_index, [9:2] ready_count, [10] running_busy, [15:11] zero
    input  logic [mlbd_pkg::SDATA_W-1:0]        s_tdata,
    // [0] kind
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] action, [3:2] source_core, [5:4] target_core, [12:6] requester_load,
    // [15:13] zero
    output logic [mlbd_pkg::MDATA_W-1:0]        m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [mlbd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [mlbd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    mlbd_pkg::state_t                 state_reg, state_next;
    logic [mlbd_pkg::MODE_W-1:0]      mode_reg;
    logic                             ipi_reg;
    logic [mlbd_pkg::MASK_W-1:0]      mask_reg;
    logic                             start_reg, start_next;
    logic [mlbd_pkg::IDX_W-1:0]       req_reg, req_next;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [mlbd_pkg::MDATA_W-1:0]     m_tdata_reg, m_tdata_next;

    logic [mlbd_pkg::ACT_W-1:0]       act_reg, act_next;
    logic [mlbd_pkg::IDX_W-1:0]       src_reg, src_next;
    logic [mlbd_pkg::IDX_W-1:0]       dst_reg, dst_next;
    logic [mlbd_pkg::LOAD_W-1:0]      rload_reg, rload_next;

    logic                             s_accept;
    logic                             bal_en;
    logic                             out_free;
    logic                             out_load;
    mlbd_pkg::cell_cmd_t              cmd;
    mlbd_pkg::token_t                 tok [mlbd_pkg::CORE_COUNT+1];
    mlbd_pkg::token_t                 tok_end;
    logic [mlbd_pkg::LOAD_W-1:0]      t_load, f_load, self_load;
    logic                             do_push, do_pull;

    assign s_accept = s_tvalid && s_tready;
    assign bal_en   = ipi_reg && (mode_reg != mlbd_pkg::MODE_NONE);
    assign out_free = !m_tvalid_reg || m_tready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= mlbd_pkg::MODE_HYBRID;
            ipi_reg  <= 1'b1;
            mask_reg <= 4'b0001;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                mlbd_pkg::REG_BALANCE_MODE: mode_reg <= cfg_wdata[mlbd_pkg::MODE_W-1:0];
                mlbd_pkg::REG_IPI_ENABLE:   ipi_reg  <= cfg_wdata[0];
                mlbd_pkg::REG_ONLINE_MASK:  mask_reg <= cfg_wdata[mlbd_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cmd.smp_we = s_accept && (s_tuser == mlbd_pkg::KIND_SAMPLE);
        cmd.upd_en = s_accept && (s_tuser == mlbd_pkg::KIND_BALANCE) && bal_en;
        cmd.core   = s_tdata[1:0];
        cmd.count  = s_tdata[9:2];
        cmd.busy   = s_tdata[10];
    end

    // Inject a fresh search word at the head of the row
    always_comb begin
        tok[0].valid     = start_reg;
        tok[0].req       = req_reg;
        tok[0].min_found = 1'b0;
        tok[0].lo_load   = '1;
        tok[0].min_idx   = '0;
        tok[0].max_found = 1'b0;
        tok[0].hi_load   = '0;
        tok[0].max_idx   = '0;
        tok[0].self_load = '0;
        tok[0].load0     = '0;
    end

    for (genvar g = 0; g < mlbd_pkg::CORE_COUNT; g++) begin : g_cell
        mlbd_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cell_idx    (mlbd_pkg::IDX_W'(g)),
            .cell_online (mask_reg[g]),
            .cmd         (cmd),
            .tok_in      (tok[g]),
            .tok_out     (tok[g+1])
        );
    end

    assign tok_end = tok[mlbd_pkg::CORE_COUNT];

    // Decision from the word leaving the last cell; an empty search falls back on core 0
    always_comb begin
        self_load = tok_end.self_load;
        t_load    = tok_end.min_found ? tok_end.lo_load : tok_end.load0;
        f_load    = tok_end.max_found ? tok_end.hi_load : tok_end.load0;
        do_push   = bal_en
                    && (mode_reg == mlbd_pkg::MODE_PUSH || mode_reg == mlbd_pkg::MODE_HYBRID)
                    && (self_load > mlbd_pkg::PUSH_LEVEL)
                    && (t_load < self_load - mlbd_pkg::LOAD_GAP);
        do_pull   = bal_en
                    && (mode_reg == mlbd_pkg::MODE_PULL || mode_reg == mlbd_pkg::MODE_HYBRID)
                    && (self_load < mlbd_pkg::PULL_LEVEL)
                    && (f_load > self_load + mlbd_pkg::LOAD_GAP);
        act_next   = act_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        rload_next = rload_reg;
        if (tok_end.valid) begin
            rload_next = self_load;
            if (do_pull) begin
                act_next = mlbd_pkg::ACT_PULL;
                src_next = tok_end.max_idx;
                dst_next = tok_end.req;
            end else if (do_push) begin
                act_next = mlbd_pkg::ACT_PUSH;
                src_next = tok_end.req;
                dst_next = tok_end.min_idx;
            end else begin
                act_next = mlbd_pkg::ACT_NONE;
                src_next = '0;
                dst_next = '0;
            end
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mlbd_pkg::ST_IDLE: begin
                if (s_accept && s_tuser == mlbd_pkg::KIND_BALANCE) begin
                    state_next = mlbd_pkg::ST_SWEEP;
                end
            end
            mlbd_pkg::ST_SWEEP: begin
                if (tok_end.valid) begin
                    state_next = mlbd_pkg::ST_RESULT;
                end
            end
            mlbd_pkg::ST_RESULT: begin
                if (out_free) begin
                    state_next = mlbd_pkg::ST_IDLE;
                end
            end
            default: state_next = mlbd_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the state machine
    always_comb begin
        s_tready   = 1'b0;
        out_load   = 1'b0;
        start_next = 1'b0;
        req_next   = req_reg;
        case (state_reg)
            mlbd_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && s_tuser == mlbd_pkg::KIND_BALANCE) begin
                    start_next = 1'b1;
                    req_next   = s_tdata[1:0];
                end
            end
            mlbd_pkg::ST_SWEEP:  ;
            mlbd_pkg::ST_RESULT: out_load = out_free;
            default: ;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {3'b0, rload_reg, dst_reg, src_reg, act_reg};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mlbd_pkg::ST_IDLE;
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            start_reg    <= start_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        m_tdata_reg <= m_tdata_next;
        act_reg     <= act_next;
        src_reg     <= src_next;
        dst_reg     <= dst_next;
        rload_reg   <= rload_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_tok_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_end.valid |-> state_reg == mlbd_pkg::ST_SWEEP)
        else $error("search word left the row outside a sweep");

    a_out_from_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !$past(m_tvalid_reg)) |-> $past(state_reg) == mlbd_pkg::ST_RESULT)
        else $error("output word raised without a finished decision");

    a_action_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tdata_reg[1:0] == mlbd_pkg::ACT_NONE
                          || m_tdata_reg[1:0] == mlbd_pkg::ACT_PUSH
                          || m_tdata_reg[1:0] == mlbd_pkg::ACT_PULL))
        else $error("undefined action code on output");

    a_no_move_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[1:0] == mlbd_pkg::ACT_NONE)
            |-> (m_tdata_reg[5:2] == '0))
        else $error("no-move decision carries core numbers");

endmodule

@@ rtl/core/mlbd_cell.sv @@
// One core's cell: sampled count, busy flag, smoothed load and one stage of the search.
module mlbd_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [mlbd_pkg::IDX_W-1:0]  cell_idx,
    input  logic                        cell_online,
    input  mlbd_pkg::cell_cmd_t         cmd,
    input  mlbd_pkg::token_t            tok_in,
    output mlbd_pkg::token_t            tok_out
);

    logic [mlbd_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                         busy_reg, busy_next;
    logic [mlbd_pkg::LOAD_W-1:0]  load_reg, load_next;
    mlbd_pkg::token_t             tok_reg, tok_next;
    logic                         is_cand;

    always_comb begin
        count_next = count_reg;
        busy_next  = busy_reg;
        load_next  = load_reg;
        if (cmd.smp_we && cmd.core == cell_idx) begin
            count_next = cmd.count;
            busy_next  = cmd.busy;
        end
        if (cmd.upd_en && cell_online) begin
            load_next = mlbd_pkg::load_avg(load_reg, mlbd_pkg::load_now(count_reg, busy_reg));
        end
    end

    // Fold this cell's load into the passing search word
    always_comb begin
        tok_next = tok_in;
        is_cand  = cell_online && (cell_idx != tok_in.req);
        if (is_cand && load_reg < tok_in.lo_load) begin
            tok_next.min_found = 1'b1;
            tok_next.lo_load   = load_reg;
            tok_next.min_idx   = cell_idx;
        end
        if (is_cand && load_reg > tok_in.hi_load) begin
            tok_next.max_found = 1'b1;
            tok_next.hi_load   = load_reg;
            tok_next.max_idx   = cell_idx;
        end
        if (cell_idx == tok_in.req) begin
            tok_next.self_load = load_reg;
        end
        if (cell_idx == '0) begin
            tok_next.load0 = load_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            load_reg  <= '0;
            tok_reg   <= '0;
        end else begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            load_reg  <= load_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule
